@@ rtl/fslps_pkg.sv @@
package fslps_pkg;

  localparam int unsigned PageIndexBitsDefault = 18;

  localparam int unsigned VersionBits = 24;
  localparam int unsigned TagBits     = 6;
  localparam int unsigned StrideBits  = 8;
  localparam int unsigned InTdataW    = 56;

  localparam logic [StrideBits-1:0] MinStride = StrideBits'(4);

  localparam logic [TagBits-1:0] TargetIdReset = TagBits'(49);
  localparam logic               BigBlockReset = 1'b0;

  typedef enum logic [0:0] {
    CFG_TARGET_ID = 1'b0,
    CFG_BIG_BLOCK = 1'b1
  } cfg_idx_e;

  // Classified record handed from the front to the back
  typedef struct packed {
    logic                   last;
    logic                   match;
    logic [VersionBits-1:0] version;
    logic [StrideBits-1:0]  stride;
  } rec_t;

endpackage

@@ rtl/fslps_front.sv @@
module fslps_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  fslps_pkg::cfg_idx_e             cfg_index_i,
  input  logic [fslps_pkg::TagBits-1:0]   cfg_data_i,
  input  logic [fslps_pkg::InTdataW-1:0]  tdata_i,
  input  logic                            tlast_i,
  output fslps_pkg::rec_t                 rec_o
);

  logic [fslps_pkg::TagBits-1:0] target_id_q;
  logic                          big_block_q;

  logic [7:0]  b2, b3, b4, b5, tag;
  logic [15:0] size_word;
  logic [6:0]  pages;
  logic        rem_nz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_id_q <= fslps_pkg::TargetIdReset;
      big_block_q <= fslps_pkg::BigBlockReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fslps_pkg::CFG_TARGET_ID: target_id_q <= cfg_data_i;
        fslps_pkg::CFG_BIG_BLOCK: big_block_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign b2        = tdata_i[7:0];
  assign b3        = tdata_i[15:8];
  assign b4        = tdata_i[23:16];
  assign b5        = tdata_i[31:24];
  assign size_word = tdata_i[47:32];
  assign tag       = tdata_i[55:48];
  assign pages     = size_word[15:9];
  assign rem_nz    = |size_word[8:0];

  always_comb begin
    rec_o.last    = tlast_i;
    rec_o.match   = (tag[fslps_pkg::TagBits-1:0] == target_id_q);
    rec_o.version = big_block_q ? {b3, b4, b5} : {b4, b3, b2};
    rec_o.stride  = fslps_pkg::MinStride;
    // matching long records skip their whole page count, rounded up
    if (rec_o.match && (fslps_pkg::StrideBits'(pages) >= fslps_pkg::MinStride)) begin
      rec_o.stride = fslps_pkg::StrideBits'(pages) + fslps_pkg::StrideBits'(rem_nz);
    end
  end

endmodule

@@ rtl/fslps_queue.sv @@
module fslps_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  fslps_pkg::rec_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output fslps_pkg::rec_t data_o,
  output logic [1:0]      level_o
);

  localparam int unsigned Depth = 2;

  fslps_pkg::rec_t mem_q [Depth];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;

  assign full_o  = (count_q == 2'(Depth));
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign level_o = count_q;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/fslps_back.sv @@
module fslps_back #(
  parameter int unsigned PageIndexBits = fslps_pkg::PageIndexBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              rec_valid_i,
  input  fslps_pkg::rec_t                   rec_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [PageIndexBits-1:0]          out_page_o,
  output logic [fslps_pkg::VersionBits-1:0] out_version_o
);

  logic [PageIndexBits-1:0]          page_cnt_q, page_cnt_d;
  logic [PageIndexBits:0]            next_exam_q, next_exam_d;
  logic [PageIndexBits-1:0]          best_page_q, best_page_d;
  logic [fslps_pkg::VersionBits-1:0] best_ver_q, best_ver_d;
  logic                              out_valid_q, out_valid_d;
  logic [PageIndexBits-1:0]          out_page_q, out_page_d;
  logic [fslps_pkg::VersionBits-1:0] out_ver_q, out_ver_d;
  logic                              examined;

  // a non-final record never needs the output slot
  assign pop_o = rec_valid_i && (!rec_i.last || !out_valid_q || out_ready_i);
  assign examined = ({1'b0, page_cnt_q} == next_exam_q);

  always_comb begin
    page_cnt_d  = page_cnt_q;
    next_exam_d = next_exam_q;
    best_page_d = best_page_q;
    best_ver_d  = best_ver_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_page_d  = out_page_q;
    out_ver_d   = out_ver_q;
    if (pop_o) begin
      if (examined) begin
        if (rec_i.match && (best_ver_q <= rec_i.version)) begin
          best_page_d = page_cnt_q;
          best_ver_d  = rec_i.version;
        end
        next_exam_d = next_exam_q + (PageIndexBits + 1)'(rec_i.stride);
      end
      page_cnt_d = page_cnt_q + PageIndexBits'(1);
      if (rec_i.last) begin
        out_valid_d = 1'b1;
        out_page_d  = best_page_d;
        out_ver_d   = best_ver_d;
        page_cnt_d  = '0;
        next_exam_d = '0;
        best_page_d = '0;
        best_ver_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_cnt_q  <= '0;
      next_exam_q <= '0;
      best_page_q <= '0;
      best_ver_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      page_cnt_q  <= page_cnt_d;
      next_exam_q <= next_exam_d;
      best_page_q <= best_page_d;
      best_ver_q  <= best_ver_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_page_q <= out_page_d;
    out_ver_q  <= out_ver_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_page_o    = out_page_q;
  assign out_version_o = out_ver_q;

endmodule

@@ rtl/flash_spare_latest_page_scan_core.sv @@
// m_axis_tvalid rises after the final record of a dump is accepted: the record is first
// written into the queue, then the back end pops it and loads the output register.
// Throughput: 1 record per cycle, set by the page/next-page update in the back end;
// a final record waits in the queue only while an earlier result is unaccepted.
// Reset (rst_ni low, asynchronous): scan state and queue cleared, target_id = 49,
// big_block = 0; no startup sweep, ready right after reset.
module flash_spare_latest_page_scan_core #(
  parameter int unsigned PAGE_INDEX_BITS = fslps_pkg::PageIndexBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  fslps_pkg::cfg_idx_e               cfg_index_i,
  input  logic [fslps_pkg::TagBits-1:0]     cfg_data_i,
  // spare_b2, spare_b3, spare_b4, spare_b5, size_word, tag_byte
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [fslps_pkg::InTdataW-1:0]    s_axis_tdata,
  input  logic                              s_axis_tlast,
  // best_page, best_version, zero padding
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [((PAGE_INDEX_BITS+fslps_pkg::VersionBits+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned OutTdataW = ((PAGE_INDEX_BITS + fslps_pkg::VersionBits + 7) / 8) * 8;

  fslps_pkg::rec_t                   front_rec;
  fslps_pkg::rec_t                   q_rec;
  logic                              q_full;
  logic                              q_valid;
  logic                              q_pop;
  logic                              q_push;
  logic [1:0]                        q_level;
  logic [PAGE_INDEX_BITS-1:0]        out_page;
  logic [fslps_pkg::VersionBits-1:0] out_version;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full;

  fslps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .tdata_i     (s_axis_tdata),
    .tlast_i     (s_axis_tlast),
    .rec_o       (front_rec)
  );

  fslps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (front_rec),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rec),
    .level_o (q_level)
  );

  fslps_back #(
    .PageIndexBits (PAGE_INDEX_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rec_valid_i   (q_valid),
    .rec_i         (q_rec),
    .pop_o         (q_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_page_o    (out_page),
    .out_version_o (out_version)
  );

  assign m_axis_tdata = OutTdataW'({out_version, out_page});

  // queue never holds more than its two entries
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_level <= 2'd2)
    else $error("record queue overfilled");

  // nothing is pushed into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (q_level != 2'd2))
    else $error("push into full record queue");

  // a result only appears after a queued record was retired
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid && !q_valid) |=> !m_axis_tvalid)
    else $error("result without a queued record");

endmodule
